### design/stpw_pkg.sv
package stpw_pkg;

	localparam int KEY_W       = 64;
	localparam int MOVE_W      = 16;
	localparam int WEIGHT_W    = 16;
	localparam int FRAC_W      = 16;
	localparam int LFSR_W      = 32;
	localparam int INDEX_OUT_W = 13;
	localparam int ENTRY_W     = KEY_W + MOVE_W + WEIGHT_W;

	// x^32 + x^22 + x^2 + x + 1, Galois form shifting right
	localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [LFSR_W-1:0] LFSR_SAFE = 32'h0000_0001;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CMP,
		ST_CHK,
		ST_MUL,
		ST_DONE
	} stpw_state_t;

	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] nxt;
		nxt = s >> 1;
		if (s[0]) begin
			nxt = nxt ^ LFSR_MASK;
		end
		return nxt;
	endfunction

endpackage

### design/stpw_ram.sv
module stpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/sorted_table_probe_weighted_pick.sv
// Weighted-pick probe of a key-sorted move table.
//
// Input channel (in_valid/in_stall) carries op, key, move, weight. An append
// (op 0) writes the next table entry and gives no result; appends to a full
// table are dropped. A query (op 1) gives one result on the output channel
// (out_valid/out_stall): found, chosen_move, first_index.
// A query runs a lower-bound binary search, each halving step a table read
// then a compare, and one read of the entry it lands on, then scans the run
// of matching entries, each entry a key check plus weight update, then the
// 16 x total multiply-compare; it checks the entry past the run, if there is
// one, then loads the output register. A query on an empty table goes
// straight to loading the output register. The table RAM has a single read
// port. in_stall is high for the whole query. The result waits in the
// output register while out_stall is high; the next request is taken
// meanwhile, but a following query holds in its final state until the
// output register is free.
// Reset empties the table (entry count 0, no clearing pass, contents left
// unknown) and loads the LFSR with 1. A write on cfg_wr_en loads the seed
// into the LFSR at once; a zero seed loads 1.
module sorted_table_probe_weighted_pick
	import stpw_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [LFSR_W-1:0]      cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   op,
	input  logic [KEY_W-1:0]       key,
	input  logic [MOVE_W-1:0]      move,
	input  logic [WEIGHT_W-1:0]    weight,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   found,
	output logic [MOVE_W-1:0]      chosen_move,
	output logic [INDEX_OUT_W-1:0] first_index
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = AW + 1;
	localparam int TW = WEIGHT_W + AW;
	localparam int PW = FRAC_W + TW;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	stpw_state_t state_q, state_d;

	logic [CW-1:0]       count_q;
	logic [AW-1:0]       left_q, right_q, idx_q, first_q;
	logic [KEY_W-1:0]    qkey_q;
	logic                hit_q;
	logic [TW-1:0]       total_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [WEIGHT_W-1:0] wgt_q;
	logic [MOVE_W-1:0]   mov_q, chosen_q;
	logic [LFSR_W-1:0]   lfsr_q, lfsr_nxt;

	logic                   out_valid_q, out_found_q;
	logic [MOVE_W-1:0]      out_move_q;
	logic [INDEX_OUT_W-1:0] out_index_q;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
	logic [KEY_W-1:0]    rd_key;
	logic [MOVE_W-1:0]   rd_move;
	logic [WEIGHT_W-1:0] rd_weight;

	logic          in_acc, out_free, key_match, search_open, scan_more;
	logic [AW-1:0] mid;
	logic [AW:0]   mid_sum;
	logic [CW-1:0] idx_inc;
	logic [PW-1:0] prod, wgt_scaled;

	stpw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign {rd_key, rd_move, rd_weight} = ram_rdata;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign mid_sum     = {1'b0, left_q} + {1'b0, right_q};
	assign mid         = mid_sum[AW:1];
	assign search_open = (left_q < right_q);
	assign key_match   = (rd_key == qkey_q);
	assign idx_inc     = CW'(idx_q) + CW'(1);
	assign scan_more   = (idx_inc < count_q);
	assign lfsr_nxt    = lfsr_step(lfsr_q);
	assign prod        = PW'(frac_q) * PW'(total_q);
	assign wgt_scaled  = PW'({wgt_q, {FRAC_W{1'b0}}});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && op == OP_QUERY) begin
					state_d = (count_q == '0) ? ST_DONE : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				state_d = search_open ? ST_CMP : ST_CHK;
			end
			ST_CMP: begin
				state_d = ST_SEARCH;
			end
			ST_CHK: begin
				state_d = key_match ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				state_d = scan_more ? ST_CHK : ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {key, move, weight};
		ram_re    = 1'b0;
		ram_raddr = left_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_we = in_acc && (op == OP_APPEND) && (count_q < DEPTH_C);
			end
			ST_SEARCH: begin
				ram_re    = 1'b1;
				ram_raddr = search_open ? mid : left_q;
			end
			ST_MUL: begin
				ram_re    = scan_more;
				ram_raddr = idx_inc[AW-1:0];
			end
			ST_CMP, ST_CHK, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			lfsr_q  <= LFSR_SAFE;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			if (cfg_wr_en) begin
				lfsr_q <= (cfg_wr_data == '0) ? LFSR_SAFE : cfg_wr_data;
			end else if (state_q == ST_CHK && key_match) begin
				lfsr_q <= lfsr_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				qkey_q   <= key;
				left_q   <= '0;
				right_q  <= AW'(count_q - CW'(1));
				hit_q    <= 1'b0;
				total_q  <= '0;
				chosen_q <= '0;
			end
			ST_SEARCH: begin
				idx_q <= left_q;
			end
			ST_CMP: begin
				if (qkey_q <= rd_key) begin
					right_q <= mid;
				end else begin
					left_q <= mid + AW'(1);
				end
			end
			ST_CHK: begin
				if (key_match) begin
					hit_q   <= 1'b1;
					total_q <= total_q + TW'(rd_weight);
					frac_q  <= lfsr_nxt[LFSR_W-1 -: FRAC_W];
					wgt_q   <= rd_weight;
					mov_q   <= rd_move;
					if (!hit_q) begin
						first_q <= idx_q;
					end
				end
			end
			ST_MUL: begin
				// later picks replace earlier ones
				if (prod < wgt_scaled) begin
					chosen_q <= mov_q;
				end
				idx_q <= idx_inc[AW-1:0];
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_found_q <= hit_q;
			out_move_q  <= chosen_q;
			out_index_q <= hit_q ? INDEX_OUT_W'(first_q) : INDEX_OUT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_found_q;
	assign chosen_move = out_move_q;
	assign first_index = out_index_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond table depth");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE && count_q < DEPTH_C))
		else $error("table write outside idle or into full table");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("LFSR locked at zero");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result without finished query");

	a_first_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && hit_q) |-> (CW'(first_q) < count_q))
		else $error("first match index outside filled table");

endmodule
